[rtl/core/sbmq_pkg.sv]
// ============================================================================
// sbmq_pkg - shared buffer multi-queue package
// Widths, pointer encoding, codes and the transfer structs of the block.
// ============================================================================
`default_nettype none

package sbmq_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int QUEUE_COUNT  = 4;
    localparam int DATA_W       = 32;
    localparam int QUEUE_W      = 2;

    // Pointers hold an entry index or the null value BUFFER_DEPTH
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int PTR_W  = $clog2(BUFFER_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [QUEUE_W-1:0] t_qnum;
    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_ptr NULL_PTR = PTR_W'(BUFFER_DEPTH);

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ENQUEUED     = 2'd0,
        ST_DROPPED_FULL = 2'd1,
        ST_DEQUEUED     = 2'd2,
        ST_UNDERFLOW    = 2'd3
    } t_status;

    typedef struct packed {
        t_op   operation;
        t_qnum queue_number;
        t_data data_value;
    } t_req;

    typedef struct packed {
        t_data   read_value;
        t_status status;
    } t_rsp;

    function automatic logic ptr_ok(input t_ptr p);
        return p < NULL_PTR;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sbmq_if.sv]
// ============================================================================
// sbmq_if - request and response channels
// Valid/ready channels carrying queue commands in and results out.
// ============================================================================
`default_nettype none

interface sbmq_req_if
    import sbmq_pkg::*;
;
    logic  valid;
    logic  ready;
    t_op   operation;
    t_qnum queue_number;
    t_data data_value;

    modport source (output valid, output operation, output queue_number,
                    output data_value, input ready);
    modport sink   (input valid, input operation, input queue_number,
                    input data_value, output ready);
endinterface

interface sbmq_rsp_if
    import sbmq_pkg::*;
;
    logic    valid;
    logic    ready;
    t_data   read_value;
    t_status status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/shared_buffer_multi_queue.sv]
// ============================================================================
// shared_buffer_multi_queue - linked-list FIFO queues in one shared buffer
// Several queues share one data store; free entries are chained in a list.
// ============================================================================
// Flow: a transferred command is held in the input register, executes when the
// result register is free, and its result is then held in the result register.
// Throughput: one command per cycle while results are taken; each command's
// pointer read, link write and free-list update close at once in engine flops.
// Reset: synchronous, active low; all queues empty, every entry on the free
// list in order, buffer contents undefined until written.
`default_nettype none

module shared_buffer_multi_queue
    import sbmq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbmq_req_if.sink    i_req,
    sbmq_rsp_if.source  o_rsp
);

    // Input register: holds one command awaiting execution
    logic r_in_valid;
    t_req r_req;

    // Result register: holds one result awaiting transfer
    logic r_out_valid;
    t_rsp r_rsp;

    logic proceed;
    t_rsp step_rsp;

    // Execute the held command when the result register can take its result
    assign proceed     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.operation    <= i_req.operation;
            r_req.queue_number <= i_req.queue_number;
            r_req.data_value   <= i_req.data_value;
        end
    end

    // Queue state and the per-command update
    sbmq_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proceed),
        .i_req   (r_req),
        .o_rsp   (step_rsp)
    );

    // Advance the result register; drop valid once the result is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed) begin
            r_rsp <= step_rsp;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_rsp.read_value;
    assign o_rsp.status     = r_rsp.status;

endmodule

`default_nettype wire

[rtl/core/sbmq_engine.sv]
// ============================================================================
// sbmq_engine - linked-list queue state and its per-command update
// Holds the shared buffer, link store, queue pointers and free-list head.
// ============================================================================
`default_nettype none

module sbmq_engine
    import sbmq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    t_data r_data_mem [BUFFER_DEPTH];
    t_ptr  r_link     [BUFFER_DEPTH];
    t_ptr  r_head     [QUEUE_COUNT];
    t_ptr  r_tail     [QUEUE_COUNT];
    t_ptr  r_free_head;

    logic  q_ok;
    t_ptr  head;
    t_ptr  tail;
    t_addr link_ra;
    t_ptr  link_rd;

    logic  link_we;
    t_addr link_wa;
    t_ptr  link_wd;
    logic  data_we;
    logic  head_we;
    t_ptr  n_head;
    logic  tail_we;
    logic  free_we;
    t_ptr  n_free_head;

    assign q_ok = 32'(i_req.queue_number) < QUEUE_COUNT;
    assign head = r_head[i_req.queue_number];
    assign tail = r_tail[i_req.queue_number];

    // One link read: the free-list head for enqueue, the queue head for dequeue
    assign link_ra = (i_req.operation == OP_DEQUEUE) ? head[ADDR_W-1:0]
                                                     : r_free_head[ADDR_W-1:0];
    assign link_rd = r_link[link_ra];

    // The tail's link is never cleared; a single-entry queue is spotted by
    // head equal to tail instead.
    always_comb begin
        link_we     = 1'b0;
        link_wa     = tail[ADDR_W-1:0];
        link_wd     = r_free_head;
        data_we     = 1'b0;
        head_we     = 1'b0;
        n_head      = r_free_head;
        tail_we     = 1'b0;
        free_we     = 1'b0;
        n_free_head = link_rd;
        o_rsp.read_value = '0;
        o_rsp.status     = ST_UNDERFLOW;
        unique case (i_req.operation)
            OP_ENQUEUE: begin
                if (q_ok && ptr_ok(r_free_head)) begin
                    o_rsp.status = ST_ENQUEUED;
                    free_we      = 1'b1;
                    data_we      = 1'b1;
                    tail_we      = 1'b1;
                    if (!ptr_ok(head)) begin
                        head_we = 1'b1;
                    end else if (ptr_ok(tail)) begin
                        link_we = 1'b1;
                    end
                end else begin
                    o_rsp.status = ST_DROPPED_FULL;
                end
            end
            OP_DEQUEUE: begin
                if (q_ok && ptr_ok(head)) begin
                    o_rsp.status     = ST_DEQUEUED;
                    o_rsp.read_value = r_data_mem[head[ADDR_W-1:0]];
                    head_we          = 1'b1;
                    n_head           = (head == tail) ? NULL_PTR : link_rd;
                    link_we          = 1'b1;
                    link_wa          = head[ADDR_W-1:0];
                    free_we          = 1'b1;
                    n_free_head      = head;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_link[i] <= PTR_W'(i + 1);
            end
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_head[i] <= NULL_PTR;
                r_tail[i] <= NULL_PTR;
            end
            r_free_head <= '0;
        end else if (i_fire) begin
            if (link_we) begin
                r_link[link_wa] <= link_wd;
            end
            if (head_we) begin
                r_head[i_req.queue_number] <= n_head;
            end
            if (tail_we) begin
                r_tail[i_req.queue_number] <= r_free_head;
            end
            if (free_we) begin
                r_free_head <= n_free_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && data_we) begin
            r_data_mem[r_free_head[ADDR_W-1:0]] <= i_req.data_value;
        end
    end

endmodule

`default_nettype wire
